/* rtl/vcti_pkg.sv */
// Shared constants, types and the reset curve for the velocity curve interpolator.
`default_nettype none
package vcti_pkg;

   // Table geometry and fixed-point format.
   localparam int TABLE_DEPTH = 128;
   localparam int IDX_W       = 7;
   localparam int VAL_W       = 16;
   localparam int FRAC_W      = 15;
   localparam int SCALED_W    = VAL_W + IDX_W - 1;
   localparam logic [VAL_W-1:0] Q15_ONE  = 16'd32768;
   localparam logic [VAL_W-1:0] Q15_HALF = 16'd16384;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   // Ramp step: each entry adds 65536/(2*(depth-1)), kept as quotient and remainder.
   localparam int RAMP_DIV    = 2 * (TABLE_DEPTH - 1);
   localparam int RAMP_STEP_Q = 65536 / RAMP_DIV;
   localparam int RAMP_STEP_R = 65536 % RAMP_DIV;

   // Item operation codes.
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_APPLY = 1'b1;

   typedef logic [TABLE_DEPTH-1:0][VAL_W-1:0] curve_tab_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic read;
      logic mul;
      logic finish;
   } cmd_type;

   // Linear ramp, entry i = i*32768/(depth-1), rounded half up.
   // The rounding offset starts the remainder at depth-1.
   function automatic curve_tab_type ramp_fn();
      curve_tab_type tab;
      int            quo;
      int            rem;
      quo = 0;
      rem = TABLE_DEPTH - 1;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         tab[i] = VAL_W'(quo);
         quo    = quo + RAMP_STEP_Q;
         rem    = rem + RAMP_STEP_R;
         if (rem >= RAMP_DIV) begin
            rem = rem - RAMP_DIV;
            quo = quo + 1;
         end
      end
      return tab;
   endfunction

   localparam curve_tab_type RAMP_TABLE = ramp_fn();

endpackage
`default_nettype wire

/* rtl/vcti_ctrl.sv */
// Controller state machine that sequences one item through the datapath.
`default_nettype none
module vcti_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output vcti_pkg::cmd_type     cmd
);
   import vcti_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_FIN  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      fin_go;

   // The last step may only run once the output register is free.
   assign fin_go = (state_ff == ST_FIN) && (!rsp_valid_ff || !rsp_stall);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_READ;
         end
         ST_READ: state_in = ST_MUL;
         ST_MUL:  state_in = ST_FIN;
         ST_FIN: begin
            if (fin_go) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output valid is set by the last step and cleared when the item is taken.
   always_comb begin
      if (fin_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Handshake outputs and datapath commands.
   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign cmd.capture = (state_ff == ST_IDLE) && req_valid;
   assign cmd.read    = (state_ff == ST_READ);
   assign cmd.mul     = (state_ff == ST_MUL);
   assign cmd.finish  = fin_go;

endmodule
`default_nettype wire

/* rtl/vcti_dp.sv */
// Datapath: curve memory, clamping of loads and interpolation of applies.
`default_nettype none
module vcti_dp (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire vcti_pkg::cmd_type            cmd,
   input  wire logic                         req_op,
   input  wire logic [vcti_pkg::IDX_W-1:0]   req_entry_index,
   input  wire logic [vcti_pkg::VAL_W-1:0]   req_entry_value,
   input  wire logic [vcti_pkg::VAL_W-1:0]   req_velocity,
   output logic [vcti_pkg::VAL_W-1:0]        rsp_result_value
);
   import vcti_pkg::*;

   // Captured item.
   logic                op_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [VAL_W-1:0]    val_ff;
   logic [SCALED_W-1:0] scaled_ff;
   logic [VAL_W-1:0]    val_sat, vel_sat;

   // Curve storage and registered reads.
   logic [VAL_W-1:0]       mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [VAL_W-1:0]       rd0_mem_ff, rd1_mem_ff, rd0_ramp_ff, rd1_ramp_ff;
   logic                   rd0_vld_ff, rd1_vld_ff;
   logic [IDX_W-1:0]       lower, upper, addr0, addr1;
   logic [VAL_W-1:0]       lo, hi;

   // Interpolation and load result.
   logic signed [VAL_W:0]          diff;
   logic signed [VAL_W-1:0]        frac_s;
   logic signed [2*VAL_W:0]        prod_ff;
   logic signed [2*VAL_W+1:0]      sum;
   logic [VAL_W-1:0]               floor_val, load_res, apply_res, result_in;
   logic [VAL_W-1:0]               result_ff;
   logic                           wr_en;

   // Saturate the incoming values to 1.0.
   assign val_sat = (req_entry_value > Q15_ONE) ? Q15_ONE : req_entry_value;
   assign vel_sat = (req_velocity > Q15_ONE) ? Q15_ONE : req_velocity;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_op;
         idx_ff    <= req_entry_index;
         val_ff    <= val_sat;
         scaled_ff <= SCALED_W'(vel_sat) * SCALED_W'(LAST_IDX);
      end
   end

   // Segment selection; the upper entry stops at the last one.
   assign lower  = scaled_ff[SCALED_W-1:FRAC_W];
   assign upper  = (lower == LAST_IDX) ? LAST_IDX : lower + IDX_W'(1);
   assign addr0  = (op_ff == OP_APPLY) ? lower : idx_ff - IDX_W'(1);
   assign addr1  = upper;

   // Memory write and two registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[idx_ff] <= load_res;
      end
      if (cmd.read) begin
         rd0_mem_ff <= mem[addr0];
         rd1_mem_ff <= mem[addr1];
      end
   end

   // An entry never written since reset reads as the ramp.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd0_vld_ff  <= valid_ff[addr0];
         rd1_vld_ff  <= valid_ff[addr1];
         rd0_ramp_ff <= RAMP_TABLE[addr0];
         rd1_ramp_ff <= RAMP_TABLE[addr1];
      end
   end

   assign lo = rd0_vld_ff ? rd0_mem_ff : rd0_ramp_ff;
   assign hi = rd1_vld_ff ? rd1_mem_ff : rd1_ramp_ff;

   // Interpolation as lo + (hi - lo) * frac, one multiply.
   assign diff   = $signed({1'b0, hi}) - $signed({1'b0, lo});
   assign frac_s = $signed({1'b0, scaled_ff[FRAC_W-1:0]});

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= diff * frac_s;
      end
   end

   assign sum       = $signed({2'b00, lo, {FRAC_W{1'b0}}}) + (2*VAL_W+2)'(prod_ff)
                      + $signed({{(VAL_W+2){1'b0}}, Q15_HALF});
   assign apply_res = sum[FRAC_W+VAL_W-1:FRAC_W];

   // A load is held at or above the entry below it.
   assign floor_val = (idx_ff == '0) ? '0 : lo;
   assign load_res  = (val_ff < floor_val) ? floor_val : val_ff;
   assign wr_en     = cmd.finish && (op_ff == OP_LOAD);
   assign result_in = (op_ff == OP_APPLY) ? apply_res : load_res;

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         result_ff <= result_in;
      end
   end

   assign rsp_result_value = result_ff;

endmodule
`default_nettype wire

/* rtl/velocity_curve_table_interpolator_top.sv */
// Top level of the velocity curve table interpolator.
//
// Usage: an item on the req_ channel either loads one curve entry (op 0) or
// maps a velocity through the curve (op 1). Each item gives exactly one item
// on the rsp_ channel: the stored clamped entry for a load, or the mapped
// Q15 velocity for an apply. Both channels move an item when valid is high
// and stall is low.
// After the input item is taken, the result becomes valid once the table
// read, the multiply and the final add have run; the capture happens at the
// accepting edge. One item is in flight at a time, so the next item is taken
// only once the current one has run through the single shared datapath.
// The output register holds a finished item, so the next input item can be
// taken while rsp_stall is high; its last step waits until the register
// frees, and req_stall stays high meanwhile.
// Reset clears the controller and marks every table entry as unwritten, so
// the curve reads as the linear ramp until entries are loaded.
`default_nettype none
module velocity_curve_table_interpolator_top (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_op,
   input  wire logic [vcti_pkg::IDX_W-1:0]   req_entry_index,
   input  wire logic [vcti_pkg::VAL_W-1:0]   req_entry_value,
   input  wire logic [vcti_pkg::VAL_W-1:0]   req_velocity,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [vcti_pkg::VAL_W-1:0]        rsp_result_value
);
   import vcti_pkg::*;

   cmd_type cmd;

   // Sequencer.
   vcti_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Table and arithmetic.
   vcti_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_op           (req_op),
      .req_entry_index  (req_entry_index),
      .req_entry_value  (req_entry_value),
      .req_velocity     (req_velocity),
      .rsp_result_value (rsp_result_value)
   );

endmodule
`default_nettype wire
